// ----- sv/gflc_pkg.sv -----
package gflc_pkg;
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int NW = AW + 1;
    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;
    typedef logic [AW-1:0] t_addr;
    typedef logic [NW-1:0] t_cnt;
    typedef struct packed {
        logic start;
        t_cnt day;
    } t_probe_req;
    typedef struct packed {
        logic done;
        logic hit;
    } t_probe_rsp;
endpackage

// ----- sv/gflc_if.sv -----
interface gflc_in_if (input logic i_clk);
    logic       valid;
    logic       ready;
    logic [6:0] flood_row;
    logic [6:0] flood_col;
    logic       is_last;
    modport source (output valid, flood_row, flood_col, is_last, input ready);
    modport sink (input valid, flood_row, flood_col, is_last, output ready);
endinterface

interface gflc_out_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [12:0] latest_day;
    modport source (output valid, latest_day, input ready);
    modport sink (input valid, latest_day, output ready);
endinterface

// ----- sv/gflc_probe.sv -----
module gflc_probe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gflc_pkg::t_probe_req i_req,
    output gflc_pkg::t_probe_rsp o_rsp,
    input  logic [6:0]           i_rows,
    input  logic [6:0]           i_cols,
    input  gflc_pkg::t_cnt       i_loaded,
    output gflc_pkg::t_cnt       o_ord_raddr,
    input  gflc_pkg::t_addr      i_ord_rdata
);
    localparam int RW = gflc_pkg::RW;
    localparam int CW = gflc_pkg::CW;
    localparam int AW = gflc_pkg::AW;
    localparam int NW = gflc_pkg::NW;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_MRD, S_MWR, S_SEED, S_POP, S_PWAIT, S_NB, S_NBCHK, S_END
    } t_state;

    logic          vis_mem [gflc_pkg::CELL_CAP];
    logic [AW-1:0] q_mem [gflc_pkg::CELL_CAP];

    t_state        r_state;
    logic [NW-1:0] r_i, r_day, r_head, r_tail;
    logic [AW-1:0] r_cur, r_nb;
    logic [1:0]    r_k;
    logic          r_nb_ok;
    logic          r_vis_q;
    logic [AW-1:0] r_q_q;
    logic          r_hit;
    logic          r_done;
    logic          r_s2;
    logic [AW-1:0] r_seed;

    logic [RW-1:0] cur_r;
    logic [CW-1:0] cur_c;
    logic [RW:0]   nr;
    logic [CW:0]   nc;
    logic          nb_in;
    logic [AW-1:0] nb_addr;

    logic          seed_ok;
    logic          nb_new;
    logic          vis_we, vis_wd;
    logic [AW-1:0] vis_wa, vis_ra;
    logic          q_we;
    logic [AW-1:0] q_wa, q_ra, q_wd;

    assign cur_r = r_cur[AW-1:CW];
    assign cur_c = r_cur[CW-1:0];
    assign o_ord_raddr = r_i;
    assign o_rsp = '{done: r_done, hit: r_hit};

    always_comb begin
        nr = {1'b0, cur_r};
        nc = {1'b0, cur_c};
        nb_in = 1'b0;
        case (r_k)
            2'd0: begin
                nc = {1'b0, cur_c} + 1'b1;
                nb_in = (nc < i_cols);
            end
            2'd1: begin
                nr = {1'b0, cur_r} + 1'b1;
                nb_in = (nr < i_rows);
            end
            2'd2: begin
                nc = {1'b0, cur_c} - 1'b1;
                nb_in = (cur_c != '0);
            end
            default: begin
                nr = {1'b0, cur_r} - 1'b1;
                nb_in = (cur_r != '0);
            end
        endcase
    end

    assign nb_addr = {nr[RW-1:0], nc[CW-1:0]};
    assign seed_ok = (r_state == S_SEED) && r_s2 && !r_vis_q;
    assign nb_new = (r_state == S_NBCHK) && r_nb_ok && !r_vis_q;
    assign q_we = seed_ok || nb_new;
    assign q_wa = r_tail[AW-1:0];
    assign q_wd = seed_ok ? r_seed : r_nb;
    assign q_ra = r_head[AW-1:0];

    always_comb begin
        vis_we = 1'b0;
        vis_wd = 1'b0;
        vis_wa = r_i[AW-1:0];
        vis_ra = r_i[AW-1:0];
        case (r_state)
            S_CLR: begin
                vis_we = 1'b1;
            end
            S_MWR: begin
                vis_wa = i_ord_rdata;
                vis_wd = 1'b1;
                vis_we = ({1'b0, i_ord_rdata[AW-1:CW]} < i_rows)
                    && ({1'b0, i_ord_rdata[CW-1:0]} < i_cols);
            end
            S_SEED: begin
                vis_wa = r_seed;
                vis_wd = 1'b1;
                vis_we = seed_ok;
            end
            S_NB: begin
                vis_ra = nb_addr;
            end
            S_NBCHK: begin
                vis_wa = r_nb;
                vis_wd = 1'b1;
                vis_we = nb_new;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        r_vis_q <= vis_mem[vis_ra];
        if (q_we) begin
            q_mem[q_wa] <= q_wd;
        end
        r_q_q <= q_mem[q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
            r_hit <= 1'b0;
            r_i <= '0;
            r_s2 <= 1'b0;
        end else begin
            r_done <= (r_state == S_END);
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_day <= i_req.day;
                        r_i <= '0;
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    if (r_i == NW'(gflc_pkg::CELL_CAP - 1)) begin
                        r_i <= '0;
                        r_state <= S_MRD;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_MRD: begin
                    if (r_i < r_day && r_i < i_loaded) begin
                        r_state <= S_MWR;
                    end else begin
                        r_i <= '0;
                        r_tail <= '0;
                        r_head <= '0;
                        r_s2 <= 1'b0;
                        r_state <= S_SEED;
                    end
                end
                S_MWR: begin
                    r_i <= r_i + 1'b1;
                    r_state <= S_MRD;
                end
                S_SEED: begin
                    r_seed <= r_i[AW-1:0];
                    if (r_s2) begin
                        if (seed_ok) begin
                            r_tail <= r_tail + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                        r_s2 <= 1'b0;
                    end else if (r_i < {{(NW-7){1'b0}}, i_cols}) begin
                        r_s2 <= 1'b1;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_head == r_tail) begin
                        r_hit <= 1'b0;
                        r_state <= S_END;
                    end else begin
                        r_state <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    r_cur <= r_q_q;
                    r_head <= r_head + 1'b1;
                    r_k <= 2'd0;
                    if ({1'b0, r_q_q[AW-1:CW]} == i_rows - 1'b1) begin
                        r_hit <= 1'b1;
                        r_state <= S_END;
                    end else begin
                        r_state <= S_NB;
                    end
                end
                S_NB: begin
                    r_nb <= nb_addr;
                    r_nb_ok <= nb_in;
                    r_state <= S_NBCHK;
                end
                S_NBCHK: begin
                    if (nb_new) begin
                        r_tail <= r_tail + 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? S_POP : S_NB;
                end
                S_END: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/grid_flood_latest_crossing_day_top.sv -----
// Loading: one cell word per cycle; ready is high only while no order is being searched.
// Search: after the last word, about log2(N) probes run one after another. Each probe
// clears the 4096-entry visited map, marks d cells, seeds the top row and floods.
// The result word is offered after the last probe; loading resumes once it is accepted.
// Synchronous active-low reset: 64x64 grid, empty order, no search pending.
module grid_flood_latest_crossing_day_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gflc_in_if.sink     s_in,
    gflc_out_if.source  m_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);
    localparam int AW = gflc_pkg::AW;
    localparam int RW = gflc_pkg::RW;
    localparam int CW = gflc_pkg::CW;
    localparam int NW = gflc_pkg::NW;

    typedef enum logic [2:0] {T_LOAD, T_CHK, T_WAIT, T_OUT} t_state;

    t_state        r_state;
    logic [6:0]    r_rows, r_cols;
    logic [NW-1:0] r_cnt, r_lo, r_hi, r_mid;
    logic [12:0]   r_best;
    logic          r_start;
    gflc_pkg::t_addr ord_mem [gflc_pkg::CELL_CAP];
    gflc_pkg::t_addr r_ord_q;
    gflc_pkg::t_cnt  ord_ra;
    gflc_pkg::t_probe_req probe_req;
    gflc_pkg::t_probe_rsp rsp;
    logic [6:0]    cfg_top;
    logic [6:0]    cfg_v;
    logic          in_ok, acc;

    assign cfg_top = (i_cfg_idx == gflc_pkg::REG_ROWS) ? 7'(gflc_pkg::MAX_ROWS)
                                                       : 7'(gflc_pkg::MAX_COLS);
    assign cfg_v = (i_cfg_data < 7'd2) ? 7'd2 : (i_cfg_data > cfg_top) ? cfg_top : i_cfg_data;
    assign s_in.ready = (r_state == T_LOAD);
    assign acc = s_in.valid && s_in.ready;
    assign in_ok = (s_in.flood_row != '0) && (s_in.flood_row <= r_rows)
        && (s_in.flood_col != '0) && (s_in.flood_col <= r_cols)
        && (r_cnt < NW'(gflc_pkg::CELL_CAP));
    assign m_out.valid = (r_state == T_OUT);
    assign m_out.latest_day = r_best;
    assign probe_req = '{start: r_start, day: r_mid};

    always_ff @(posedge i_clk) begin
        if (acc && in_ok) begin
            ord_mem[r_cnt[AW-1:0]] <= {RW'(s_in.flood_row - 1'b1),
                                       CW'(s_in.flood_col - 1'b1)};
        end
        r_ord_q <= ord_mem[ord_ra[AW-1:0]];
    end

    gflc_probe u_probe (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(probe_req), .o_rsp(rsp),
        .i_rows(r_rows), .i_cols(r_cols), .i_loaded(r_cnt),
        .o_ord_raddr(ord_ra), .i_ord_rdata(r_ord_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_LOAD;
            r_rows <= 7'(gflc_pkg::MAX_ROWS);
            r_cols <= 7'(gflc_pkg::MAX_COLS);
            r_cnt <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= (r_state == T_CHK) && (r_lo < r_hi);
            if (i_cfg_we) begin
                if (i_cfg_idx == gflc_pkg::REG_ROWS) r_rows <= cfg_v;
                else r_cols <= cfg_v;
            end
            case (r_state)
                T_LOAD: begin
                    if (acc) begin
                        if (in_ok) r_cnt <= r_cnt + 1'b1;
                        if (s_in.is_last) begin
                            r_lo <= NW'(1);
                            r_hi <= in_ok ? r_cnt : ((r_cnt == '0) ? '0 : r_cnt - 1'b1);
                            r_best <= '0;
                            r_state <= T_CHK;
                        end
                    end
                end
                T_CHK: begin
                    if (r_lo < r_hi) begin
                        r_mid <= r_lo + ((r_hi - r_lo) >> 1);
                        r_state <= T_WAIT;
                    end else begin
                        r_state <= T_OUT;
                    end
                end
                T_WAIT: begin
                    if (rsp.done) begin
                        if (rsp.hit) begin
                            r_best <= 13'(r_mid);
                            r_lo <= r_mid + 1'b1;
                        end else begin
                            r_hi <= r_mid;
                        end
                        r_state <= T_CHK;
                    end
                end
                T_OUT: begin
                    if (m_out.ready) begin
                        r_cnt <= '0;
                        r_state <= T_LOAD;
                    end
                end
                default: r_state <= T_LOAD;
            endcase
        end
    end

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_WAIT) |-> !s_in.ready) else $error("ready while searching");
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_WAIT) |-> (r_mid >= r_lo && r_mid < r_hi)) else $error("mid out");
    a_start_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> !r_start) else $error("double start");
endmodule

// ----- tb/gflc_tb_if.sv -----
`timescale 1ns / 100ps

// The channel interfaces are compiled from the RTL tree; this file only
// collects the word layout that the stimulus queue uses.
package gflc_tb_pkg;
    typedef struct {
        logic [6:0] row;
        logic [6:0] col;
        logic       last;
    } cell_word_t;
endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import gflc_pkg::*;
    import gflc_tb_pkg::*;

    localparam int LIMIT_CYCLES = 40_000_000;
    localparam int FULL_SIDE = 16;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [6:0] cfg_data;

    gflc_in_if  in_if (i_clk);
    gflc_out_if out_if (i_clk);

    grid_flood_latest_crossing_day_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (in_if),
        .m_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cell_word_t  cell_q[$];
    logic [12:0] day_exp_q[$];

    // Predictor state.
    int          rows_now = 64;
    int          cols_now = 64;
    int          order_mem[CELL_CAP];
    int          order_cnt = 0;
    bit          wet[CELL_CAP];
    int          bfs_q[CELL_CAP];

    bit          quiet = 0;
    bit          hold_pending = 0;
    int          hold_left = 0;
    int          words_sent = 0;
    int          days_seen = 0;
    int          mismatches = 0;
    longint      cycles = 0;

    function automatic bit probe_crossing(int day);
        int head;
        int tail;
        int idx;
        int r;
        int c;
        int nr;
        int nc;
        int n;
        for (int i = 0; i < CELL_CAP; i++) wet[i] = 0;
        for (int i = 0; i < day && i < order_cnt; i++) begin
            idx = order_mem[i];
            if (idx / MAX_COLS < rows_now && idx % MAX_COLS < cols_now) wet[idx] = 1;
        end
        head = 0;
        tail = 0;
        for (int k = 0; k < cols_now; k++) begin
            if (!wet[k]) begin
                wet[k] = 1;
                bfs_q[tail++] = k;
            end
        end
        while (head < tail) begin
            idx = bfs_q[head++];
            r = idx / MAX_COLS;
            c = idx % MAX_COLS;
            if (r == rows_now - 1) return 1;
            for (int k = 0; k < 4; k++) begin
                nr = r + ((k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? 0 : -1);
                nc = c + ((k == 0) ? 1 : (k == 1) ? 0 : (k == 2) ? -1 : 0);
                if (nr < 0 || nr >= rows_now || nc < 0 || nc >= cols_now) continue;
                n = nr * MAX_COLS + nc;
                if (wet[n]) continue;
                wet[n] = 1;
                if (tail < CELL_CAP) bfs_q[tail++] = n;
            end
        end
        return 0;
    endfunction

    function automatic logic [12:0] latest_crossing();
        int lo;
        int hi;
        int mid;
        int best;
        lo = 1;
        hi = order_cnt - 1;
        best = 0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (probe_crossing(mid)) begin
                best = mid;
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        order_cnt = 0;
        return best[12:0];
    endfunction

    function automatic int clamp_dim(int v);
        if (v < 2) return 2;
        if (v > 64) return 64;
        return v;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (cell_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
                in_if.flood_row <= cell_q[0].row;
                in_if.flood_col <= cell_q[0].col;
                in_if.is_last   <= cell_q[0].last;
                in_if.valid     <= 1;
                void'(cell_q.pop_front());
            end else begin
                in_if.valid <= 0;
            end
        end
    end

    // Input monitor and prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            words_sent <= words_sent + 1;
            if (in_if.flood_row >= 1 && in_if.flood_row <= rows_now &&
                in_if.flood_col >= 1 && in_if.flood_col <= cols_now &&
                order_cnt < CELL_CAP) begin
                order_mem[order_cnt] = (in_if.flood_row - 1) * MAX_COLS + (in_if.flood_col - 1);
                order_cnt++;
            end
            if (in_if.is_last) day_exp_q.push_back(latest_crossing());
        end
    end

    // Result receiver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= (hold_left == 1);
        end else if (hold_pending && out_if.valid) begin
            hold_pending <= 0;
            hold_left <= 3000;
            out_if.ready <= 0;
        end else begin
            out_if.ready <= quiet || $urandom_range(0, 99) >= 11;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            days_seen <= days_seen + 1;
            if (day_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: latest_day %0d", out_if.latest_day);
            end else begin
                if (out_if.latest_day !== day_exp_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("latest_day mismatch: expected %0d actual %0d",
                                 day_exp_q[0], out_if.latest_day);
                end
                void'(day_exp_q.pop_front());
            end
        end
    end

    task automatic wait_drained();
        while (cell_q.size() != 0 || in_if.valid || day_exp_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int val);
        wait_drained();
        @(posedge i_clk);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val[6:0];
        if (idx == REG_ROWS) rows_now = clamp_dim(val & 127);
        else cols_now = clamp_dim(val & 127);
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    task automatic push_word(int r, int c, bit last);
        cell_word_t w;
        w.row = r[6:0];
        w.col = c[6:0];
        w.last = last;
        cell_q.push_back(w);
    endtask

    // One flood order of n distinct cells, with occasional stray and repeated words.
    task automatic push_order(int n, bit noisy);
        bit used[CELL_CAP];
        int r;
        int c;
        int prev;
        prev = -1;
        if (n > rows_now * cols_now) n = rows_now * cols_now;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 99) < 6)
                push_word($urandom_range(0, 127), $urandom_range(0, 127), 0);
            if (noisy && prev >= 0 && $urandom_range(0, 99) < 3)
                push_word(prev / MAX_COLS + 1, prev % MAX_COLS + 1, 0);
            do begin
                r = $urandom_range(0, rows_now - 1);
                c = $urandom_range(0, cols_now - 1);
            end while (used[r * MAX_COLS + c]);
            used[r * MAX_COLS + c] = 1;
            prev = r * MAX_COLS + c;
            push_word(r + 1, c + 1, (i == n - 1) && !(noisy && $urandom_range(0, 9) == 0));
        end
        if (n == 0 || !cell_q[$].last) push_word(0, $urandom_range(0, 127), 1);
    endtask

    task automatic run_random(int rows, int cols, int words, int max_len);
        int target;
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        target = words_sent + cell_q.size() + words;
        while (words_sent + cell_q.size() < target) begin
            push_order($urandom_range(2, max_len), 1);
            while (cell_q.size() > 50) @(posedge i_clk);
        end
    endtask

    initial begin
        int perm[CELL_CAP];
        int j;
        int t;
        i_rst_n = 0;
        cfg_we = 0;
        cfg_idx = 0;
        cfg_data = 0;
        in_if.valid = 0;
        in_if.flood_row = 0;
        in_if.flood_col = 0;
        in_if.is_last = 0;
        out_if.ready = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty order, single cell, stray last word, corner cells.
        push_word(0, 0, 1);
        push_word(1, 1, 1);
        push_word(64, 64, 0);
        push_word(65, 1, 1);
        push_word(1, 64, 0);
        push_word(64, 1, 0);
        push_word(127, 127, 1);
        wait_drained();
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 1);
        push_word(1, 1, 0);
        push_word(2, 2, 0);
        push_word(1, 2, 0);
        push_word(1, 2, 0);
        push_word(3, 1, 1);
        wait_drained();
        write_reg(REG_ROWS, 4);
        write_reg(REG_COLS, 4);
        push_word(4, 4, 0);
        push_word(1, 1, 0);
        push_word(3, 2, 0);
        push_word(2, 3, 0);
        // The grid shrinks while the order is half loaded.
        write_reg(REG_ROWS, 3);
        push_word(2, 2, 0);
        push_word(1, 3, 1);
        write_reg(REG_ROWS, 127);
        write_reg(REG_COLS, 100);
        push_word(64, 64, 0);
        push_word(1, 64, 0);
        push_word(64, 1, 1);

        // Every cell of a mid-size grid flooded, then extra words.
        write_reg(REG_ROWS, FULL_SIDE);
        write_reg(REG_COLS, FULL_SIDE);
        for (int i = 0; i < FULL_SIDE * FULL_SIDE; i++) perm[i] = i;
        for (int i = FULL_SIDE * FULL_SIDE - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < FULL_SIDE * FULL_SIDE; i++) begin
            push_word(perm[i] / FULL_SIDE + 1, perm[i] % FULL_SIDE + 1, 0);
            while (cell_q.size() > 50) @(posedge i_clk);
        end
        push_word(1, 1, 0);
        push_word(FULL_SIDE, FULL_SIDE, 1);

        run_random(64, 64, 120, 120);
        quiet = 1;
        run_random(8, 8, 200, 64);
        quiet = 0;
        run_random(2, 64, 120, 128);
        run_random(64, 2, 120, 128);
        run_random(2, 2, 50, 4);
        hold_pending = 1;
        run_random(5, 13, 200, 65);
        for (int i = 0; i < 6; i++) begin
            wait_drained();
            push_order($urandom_range(2, 40), 1);
        end
        run_random(16, 9, 160, 144);
        run_random(33, 31, 160, 200);

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("summary: %0d cell words sent, %0d crossing days checked", words_sent, days_seen);
        $display("summary: grids from 2x2 to 64x64, a fully flooded grid, stray and repeated cells");
        if (mismatches == 0 && day_exp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, day_exp_q.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
